[rtl/cma_pkg.sv]
// Shared types for the conflict mask aggregate unit.
// No dependencies.
package cma_pkg;

  typedef struct packed {
    logic full;
    logic empty;
  } cma_q_status_t;

endpackage

[rtl/cma_front.sv]
// Front end: accepts words, compares each against earlier lanes of its batch,
// folds the mask into per-lane accumulators, and queues a snapshot on the last word.
// Depends on cma_pkg.
module cma_front #(
  parameter int LANES      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic [VALUE_BITS-1:0]                 value,
  input  logic                                  end_of_stream,
  input  cma_pkg::cma_q_status_t                q_status,
  output logic                                  full,
  output logic                                  snap_push,
  output logic [LANES-1:0][LANES-2:0]           snap_data
);
  import cma_pkg::*;

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [LW-1:0] LAST_POS = LW'(LANES - 1);

  logic [LW-1:0]                   pos;
  logic [LANES-2:0][VALUE_BITS-1:0] batch;
  logic [LANES-1:0][LANES-2:0]     acc;
  logic [LANES-2:0]                hit;
  logic [LANES-2:0]                acc_upd;
  logic                            accept;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  always_comb begin
    for (int j = 0; j < LANES - 1; j++) begin
      hit[j] = (LW'(j) < pos) && (batch[j] == value);
    end
    acc_upd = acc[pos] | hit;
    snap_data = acc;
    snap_data[pos] = acc_upd;
  end

  assign snap_push = accept && end_of_stream;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      for (int i = 0; i < LANES; i++) begin
        acc[i] <= '0;
      end
    end else if (accept) begin
      if (end_of_stream) begin
        pos <= '0;
        for (int i = 0; i < LANES; i++) begin
          acc[i] <= '0;
        end
      end else begin
        acc[pos] <= acc_upd;
        pos <= (pos == LAST_POS) ? '0 : pos + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos != LAST_POS)) begin
      batch[pos[$clog2(LANES-1 > 1 ? LANES-1 : 2)-1:0]] <= value;
    end
  end

endmodule

[rtl/cma_queue.sv]
// Two-entry queue of accumulator snapshots between front and back end.
// Depends on cma_pkg.
module cma_queue #(
  parameter int LANES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [LANES-1:0][LANES-2:0] wr_data,
  input  logic                        rd_en,
  output logic [LANES-1:0][LANES-2:0] rd_data,
  output cma_pkg::cma_q_status_t      status
);
  import cma_pkg::*;

  logic [1:0][LANES-1:0][LANES-2:0] entries;
  logic                             wr_ptr;
  logic                             rd_ptr;
  logic [1:0]                       count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign rd_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

[rtl/cma_back.sv]
// Back end: walks the head snapshot lane by lane into an output register.
// Depends on cma_pkg.
module cma_back #(
  parameter int LANES = 16
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  cma_pkg::cma_q_status_t                          q_status,
  input  logic [LANES-1:0][LANES-2:0]                     q_data,
  output logic                                            q_pop,
  input  logic                                            pop,
  output logic                                            empty,
  output logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0]    lane,
  output logic [LANES-2:0]                                conflict_mask,
  output logic                                            last_lane
);
  import cma_pkg::*;

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [LW-1:0] LAST_POS = LW'(LANES - 1);

  logic [LW-1:0] idx;
  logic          out_valid;
  logic          load;

  assign empty = !out_valid;
  assign load  = !q_status.empty && (!out_valid || pop);
  assign q_pop = load && (idx == LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= (idx == LAST_POS) ? '0 : idx + LW'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane          <= idx;
      conflict_mask <= q_data[idx];
      last_lane     <= (idx == LAST_POS);
    end
  end

endmodule

[rtl/conflict_mask_aggregate_unit.sv]
// Top level of the conflict mask aggregate unit: front end, snapshot queue, back end.
// Depends on cma_pkg, cma_front, cma_queue, cma_back.
//
// Takes one word per cycle while full is low; each word is compared in parallel
// with the earlier words of its batch of LANES and its conflict mask is OR-ed into
// that lane's accumulator. A word with end_of_stream set hands a snapshot of all
// accumulators to a two-entry queue and clears them, so the next stream starts at
// once. The result side drains one snapshot as LANES results, one per cycle while
// pop is high, lane 0 first, last_lane set on the final one; the snapshot is first
// written into the queue, then its lanes into the output register. full rises only
// while both queue entries wait: streams back to back faster than results drain.
module conflict_mask_aggregate_unit #(
  parameter int LANES      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         push,
  output logic                                         full,
  input  logic [VALUE_BITS-1:0]                        value,
  input  logic                                         end_of_stream,
  input  logic                                         pop,
  output logic                                         empty,
  output logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] lane,
  output logic [LANES-2:0]                             conflict_mask,
  output logic                                         last_lane
);
  import cma_pkg::*;

  cma_q_status_t               q_status;
  logic                        snap_push;
  logic [LANES-1:0][LANES-2:0] snap_data;
  logic [LANES-1:0][LANES-2:0] head_data;
  logic                        q_pop;

  cma_front #(
    .LANES      (LANES),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .value         (value),
    .end_of_stream (end_of_stream),
    .q_status      (q_status),
    .full          (full),
    .snap_push     (snap_push),
    .snap_data     (snap_data)
  );

  cma_queue #(
    .LANES (LANES)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (snap_push),
    .wr_data (snap_data),
    .rd_en   (q_pop),
    .rd_data (head_data),
    .status  (q_status)
  );

  cma_back #(
    .LANES (LANES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_data        (head_data),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .lane          (lane),
    .conflict_mask (conflict_mask),
    .last_lane     (last_lane)
  );

endmodule

[sim/conflict_mask_aggregate_unit_tb.sv]
// Testbench for conflict_mask_aggregate_unit: drives streams of words and checks
// each reported lane mask.
// A predictor of its own folds every accepted word; the results are compared in order as they pop.
// Depends on rtl/conflict_mask_aggregate_unit.sv only.
module conflict_mask_aggregate_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES       = 16;
  localparam int VALUE_BITS  = 32;
  localparam int LANE_BITS   = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 135;

  typedef struct packed {
    logic [LANE_BITS-1:0] lane;
    logic [LANES-2:0]     mask;
    logic                 last;
  } lane_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  end_of_stream = 1'b0;
  logic                  pop = 1'b0;
  logic                  empty;
  logic [LANE_BITS-1:0]  lane;
  logic [LANES-2:0]      conflict_mask;
  logic                  last_lane;

  // predictor state
  logic [LANE_BITS-1:0]  next_lane;
  logic [VALUE_BITS-1:0] batch_words [LANES-1];
  logic [LANES-2:0]      lane_masks [LANES];
  lane_report_t          pending_reports [$];

  logic [VALUE_BITS-1:0] word_pool [4];
  int errors = 0;
  int words_sent = 0;
  int idle_pct = 0;
  int pop_hold = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  conflict_mask_aggregate_unit #(
    .LANES(LANES),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .value(value),
    .end_of_stream(end_of_stream),
    .pop(pop),
    .empty(empty),
    .lane(lane),
    .conflict_mask(conflict_mask),
    .last_lane(last_lane)
  );

  always #5 clk = ~clk;

  function automatic void clear_lanes();
    next_lane = '0;
    for (int i = 0; i < LANES; i++) lane_masks[i] = '0;
  endfunction

  function automatic void fold_word(logic [VALUE_BITS-1:0] v, logic eos);
    logic [LANES-2:0] hits;
    lane_report_t rep;
    hits = '0;
    for (int j = 0; j < LANES - 1; j++) begin
      if (j < next_lane && batch_words[j] == v) hits[j] = 1'b1;
    end
    lane_masks[next_lane] = lane_masks[next_lane] | hits;
    if (next_lane < LANES - 1) batch_words[next_lane] = v;
    next_lane = next_lane + 1'b1;
    if (eos) begin
      for (int i = 0; i < LANES; i++) begin
        rep.lane = i[LANE_BITS-1:0];
        rep.mask = lane_masks[i];
        rep.last = (i == LANES - 1);
        pending_reports.push_back(rep);
      end
      clear_lanes();
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_lanes();
    end else if (push && !full) begin
      fold_word(value, end_of_stream);
    end
  end

  always @(posedge clk) begin
    lane_report_t exp;
    if (!rst && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected word, lane", lane, 0);
      end else begin
        exp = pending_reports.pop_front();
        if (lane !== exp.lane) report_mismatch("lane", lane, exp.lane);
        if (conflict_mask !== exp.mask) begin
          report_mismatch("conflict_mask", conflict_mask, exp.mask);
        end
        if (last_lane !== exp.last) report_mismatch("last_lane", last_lane, exp.last);
      end
    end
  end

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      pop_hold = $urandom_range(1, 19) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("conflict_mask_aggregate_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic eos);
    int gap;
    push <= 1'b1;
    value <= v;
    end_of_stream <= eos;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
    @(negedge clk);
    if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 19);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic void refresh_pool();
    for (int i = 0; i < 4; i++) word_pool[i] = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      word_pool[1] = word_pool[0] ^ (32'h1 << $urandom_range(0, 31));
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      6: pick_word = '0;
      7: pick_word = '1;
      8, 9: pick_word = $urandom;
      default: pick_word = word_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  task automatic send_stream(input int len);
    refresh_pool();
    for (int i = 0; i < len; i++) send_word(pick_word(), i == len - 1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic test_lone_word();
    send_word('1, 1'b1);
  endtask

  task automatic test_full_batch_equal();
    for (int i = 0; i < LANES; i++) send_word('1, i == LANES - 1);
  endtask

  task automatic test_partial_batch();
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h8000_0000, 1'b1);
  endtask

  // short streams while results are held back fill the snapshot queue
  task automatic test_back_to_back_short();
    push <= 1'b0;
    @(posedge clk);
    pop_hold = 40;
    @(negedge clk);
    send_word('0, 1'b1);
    send_word(32'h5555_5555, 1'b1);
    send_word(32'hAAAA_AAAA, 1'b1);
    send_word('0, 1'b1);
  endtask

  task automatic test_pause_until_drained();
    idle_pct = 25;
    send_stream(3);
    wait_drained();
    send_stream(18);
  endtask

  task automatic test_random_streams();
    int len;
    while (words_sent < RANDOM_WORDS) begin
      idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if ($urandom_range(0, 4) == 0) len = $urandom_range(17, 40);
      else len = $urandom_range(1, 20);
      send_stream(len);
    end
    calm = 1'b1;
    send_stream(LANES + 3);
    send_stream(5);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_lone_word();
    test_full_batch_equal();
    test_partial_batch();
    test_back_to_back_short();
    test_pause_until_drained();
    test_random_streams();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("conflict_mask_aggregate_unit_tb: done, clean");
    end else begin
      $display("conflict_mask_aggregate_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cma_pkg.sv
rtl/cma_front.sv
rtl/cma_queue.sv
rtl/cma_back.sv
rtl/conflict_mask_aggregate_unit.sv
sim/conflict_mask_aggregate_unit_tb.sv
